// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define WLH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is high.
`define WLH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define WLH_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wlh_pkg.sv =====
// Types and constants of the word length histogram.
package wlh_pkg;

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [5:0] BINS_RESET = 6'd30;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_byte;
    logic [4:0] bin_index;
  } item_t;

  typedef struct packed {
    logic        word_ended;
    logic [5:0]  word_length;
    logic [15:0] bin_count;
    logic [4:0]  highest_used;
  } result_t;

endpackage

// ===== hdl/word_length_histogram.sv =====
// Word length histogram: one item a cycle unless the output stalls.
// The bin memory is read at the input transfer and written back when the item leaves
// stage 1, with the last write forwarded to a following read. From input transfer to
// result valid an item passes stage 1 and the output register, and waits while they stall.
// Synchronous reset clears the valid bit of every bin at once (no clearing pass),
// zeroes the open word and highest bin, and sets bins_in_use to 30.
module word_length_histogram #(
  parameter int MAX_BINS    = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_enable,
  input  logic [5:0]       cfg_write_data,
  input  logic             item_valid,
  output logic             item_stall,
  input  wlh_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output wlh_pkg::result_t result
);
  import wlh_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int LW = $clog2(MAX_BINS + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [5:0]             bins_in_use;
  logic [LW-1:0]          current_length;
  logic [AW-1:0]          highest_bin;
  logic [MAX_BINS-1:0]    bin_valid;
  logic [COUNT_WIDTH-1:0] bins_mem [MAX_BINS];
  logic [COUNT_WIDTH-1:0] rdata;

  // stage 1
  logic          s1_valid;
  logic          s1_close;
  logic          s1_read;
  logic          s1_clear;
  logic          s1_in_range;
  logic [AW-1:0] s1_addr;
  logic [5:0]    s1_len;

  // last write, forwarded to a read issued on the same edge
  logic                   fwd_valid;
  logic [AW-1:0]          fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  logic                   accept;
  logic                   s1_go;
  logic [LW-1:0]          nbins;
  logic                   is_sep;
  logic                   close;
  logic [LW-1:0]          len;
  logic [AW-1:0]          addr;
  logic                   in_range;
  logic [LW-1:0]          current_length_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [AW-1:0]          highest_bin_next;
  logic                   wr_en;

  assign s1_go      = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_go;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    if (bins_in_use == '0) begin
      nbins = LW'(1);
    end else if (32'(bins_in_use) > MAX_BINS) begin
      nbins = LW'(MAX_BINS);
    end else begin
      nbins = LW'(bins_in_use);
    end
  end

  assign is_sep = (item.char_byte == CHAR_SPACE) || (item.char_byte == CHAR_TAB) ||
                  (item.char_byte == CHAR_NEWLINE);
  assign close  = (item.opcode == OP_CHAR) && is_sep && (current_length != '0);
  assign len    = (current_length > nbins) ? nbins : current_length;
  assign in_range = 32'(item.bin_index) < MAX_BINS;

  always_comb begin
    if (close) begin
      addr = AW'(len - LW'(1));
    end else begin
      addr = AW'(item.bin_index);
    end
  end

  always_comb begin
    current_length_next = current_length;
    if (item.opcode == OP_CHAR) begin
      if (is_sep) begin
        current_length_next = '0;
      end else if (current_length < nbins) begin
        current_length_next = current_length + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use    <= BINS_RESET;
      current_length <= '0;
    end else begin
      if (cfg_write_enable) begin
        bins_in_use <= cfg_write_data;
      end
      if (accept) begin
        current_length <= current_length_next;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_close    <= close;
      s1_read     <= item.opcode == OP_READ;
      s1_clear    <= item.opcode == OP_CLEAR;
      s1_in_range <= in_range;
      s1_addr     <= addr;
      s1_len      <= close ? 6'(len) : 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Count as it stands after all earlier items
  always_comb begin
    if (!bin_valid[s1_addr]) begin
      count = '0;
    end else if (fwd_valid && (fwd_addr == s1_addr)) begin
      count = fwd_data;
    end else begin
      count = rdata;
    end
  end

  assign count_inc = (count == COUNT_MAX) ? count : count + COUNT_WIDTH'(1);
  assign wr_en     = s1_go && s1_close;

  always_comb begin
    highest_bin_next = highest_bin;
    if (s1_clear) begin
      highest_bin_next = '0;
    end else if (s1_close && (s1_addr > highest_bin)) begin
      highest_bin_next = s1_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= bins_mem[addr];
    end
    if (wr_en) begin
      bins_mem[s1_addr] <= count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid   <= '0;
      highest_bin <= '0;
      fwd_valid   <= 1'b0;
    end else if (s1_go) begin
      highest_bin <= highest_bin_next;
      if (s1_clear) begin
        bin_valid <= '0;
        fwd_valid <= 1'b0;
      end else if (s1_close) begin
        bin_valid[s1_addr] <= 1'b1;
        fwd_valid          <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1_addr;
      fwd_data <= count_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s1_go) begin
      result.word_ended   <= s1_close;
      result.word_length  <= s1_len;
      result.bin_count    <= (s1_read && s1_in_range) ? 16'(count) : 16'd0;
      result.highest_used <= 5'(highest_bin_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/wlh_checker.sv =====
// Port-level checker for the word length histogram and its bind.
`include "assert_macros.svh"

module wlh_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input wlh_pkg::result_t result
);
  import wlh_pkg::*;

  `WLH_ASSERT_IMP(a_len_with_end, clk, rst, result_valid, (result.word_ended == 1'b1) == (result.word_length != 6'd0), "word_length must be non-zero exactly when a word ended")
  `WLH_ASSERT_IMP(a_no_count_on_end, clk, rst, result_valid && result.word_ended, result.bin_count == 16'd0, "bin_count must be zero on a word end")
  `WLH_ASSERT_IMP(a_stall_only_when_full, clk, rst, item_valid && item_stall, result_valid && result_stall, "input held off while the output is free")
  `WLH_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
  `WLH_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !result_valid, "result valid straight after reset")

endmodule

bind word_length_histogram wlh_checker u_wlh_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== dv/tb_word_length_histogram.sv =====
// Self-checking testbench for the word length histogram: directed text, random text and bin settings.
module tb_word_length_histogram;
  import wlh_pkg::*;

  localparam int          BIN_SLOTS      = 32;
  localparam logic [15:0] COUNT_FULL     = 16'hFFFF;
  localparam logic [1:0]  OP_IGNORED     = 2'd3;
  localparam int          DRAIN_SLACK    = 4;
  localparam int          LONG_HOLD      = 80;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          REPORT_LIMIT   = 10;

  class length_histogram_tracker;
    bit [15:0] bin_totals[BIN_SLOTS];
    bit [5:0]  open_length;
    bit [4:0]  top_bin;
    bit [5:0]  bins_setting;
    result_t   pending_reports[$];
    int        mismatches;
    int        unexpected;
    int        words_closed;
    int        reads;
    int        clears;

    function new();
      foreach (bin_totals[i]) bin_totals[i] = '0;
      open_length  = '0;
      top_bin      = '0;
      bins_setting = BINS_RESET;
      mismatches   = 0;
      unexpected   = 0;
      words_closed = 0;
      reads        = 0;
      clears       = 0;
    endfunction

    static function bit is_blank(logic [7:0] ch);
      return ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_NEWLINE;
    endfunction

    function void set_bins(logic [5:0] value);
      bins_setting = value;
    endfunction

    function int unsigned active_bins();
      int unsigned n;
      n = bins_setting;
      if (n == 0) n = 1;
      if (n > BIN_SLOTS) n = BIN_SLOTS;
      return n;
    endfunction

    // Work out the result of one accepted input transfer and queue it.
    function void note_item(item_t it);
      result_t     r;
      int unsigned n;
      int unsigned len;
      r = '0;
      n = active_bins();
      case (it.opcode)
        OP_CHAR: begin
          if (is_blank(it.char_byte)) begin
            if (open_length != 0) begin
              len = open_length;
              if (len > n) len = n;
              if (bin_totals[len - 1] != COUNT_FULL) bin_totals[len - 1]++;
              if (len - 1 > top_bin) top_bin = 5'(len - 1);
              r.word_ended  = 1'b1;
              r.word_length = 6'(len);
              open_length   = '0;
              words_closed++;
            end
          end else if (open_length < n) begin
            open_length++;
          end
        end
        OP_READ: begin
          r.bin_count = bin_totals[it.bin_index];
          reads++;
        end
        OP_CLEAR: begin
          foreach (bin_totals[i]) bin_totals[i] = '0;
          top_bin = '0;
          clears++;
        end
        default: ;
      endcase
      r.highest_used = top_bin;
      pending_reports.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_reports.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= REPORT_LIMIT)
          $display("unexpected result: ended=%0d len=%0d count=%0d top=%0d",
                   got.word_ended, got.word_length, got.bin_count, got.highest_used);
        return;
      end
      want = pending_reports.pop_front();
      if (got.word_ended !== want.word_ended || got.word_length !== want.word_length ||
          got.bin_count !== want.bin_count || got.highest_used !== want.highest_used) begin
        mismatches++;
        if (mismatches + unexpected <= REPORT_LIMIT)
          $display({"mismatch: expected ended=%0d len=%0d count=%0d top=%0d, ",
                    "got ended=%0d len=%0d count=%0d top=%0d"},
                   want.word_ended, want.word_length, want.bin_count, want.highest_used,
                   got.word_ended, got.word_length, got.bin_count, got.highest_used);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [5:0]  cfg_write_data = '0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;

  length_histogram_tracker tracker = new();

  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;
  bit hold_request   = 1'b0;
  int stall_left     = 0;
  int items_offered  = 0;
  int settings_written = 0;

  word_length_histogram i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item             (item),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) tracker.note_item(item);
      if (result_valid && !result_stall) tracker.check_result(result);
    end
  end

  // Receiver: short random stall bursts, or one long hold-off on request.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      stall_left   = LONG_HOLD;
    end else if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("word_length_histogram verification failed");
    $finish;
  end

  function automatic item_t make_item(logic [1:0] op, logic [7:0] ch, logic [4:0] idx);
    item_t it;
    it.opcode    = op;
    it.char_byte = ch;
    it.bin_index = idx;
    return it;
  endfunction

  function automatic logic [7:0] random_word_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (length_histogram_tracker::is_blank(b)) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] random_separator();
    case ($urandom_range(0, 2))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      default: return CHAR_NEWLINE;
    endcase
  endfunction

  // Offer one item and hold it until the transfer; valid stays high afterwards.
  task automatic send_item(input item_t it);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_offered++;
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_item(make_item(OP_CHAR, ch, 5'($urandom)));
  endtask

  task automatic read_bin(input logic [4:0] idx);
    send_item(make_item(OP_READ, 8'($urandom), idx));
  endtask

  task automatic open_word(input int len);
    for (int k = 0; k < len; k++) send_char(random_word_byte());
  endtask

  task automatic wait_until_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_bins(input logic [5:0] value);
    wait_until_drained();
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    tracker.set_bins(value);
    settings_written++;
  endtask

  // Mostly well-formed words with random content; reads, clears and noise mixed in.
  task automatic run_text(input int budget);
    int start;
    int len;
    int pick;
    start = items_offered;
    while (items_offered - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          send_char(random_word_byte());
          if ($urandom_range(0, 49) == 0) read_bin(5'($urandom));
        end
        send_char(random_separator());
        if ($urandom_range(0, 4) == 0) send_char(random_separator());
      end else if (pick < 85) begin
        read_bin(5'($urandom));
      end else if (pick < 88) begin
        send_item(make_item(OP_CLEAR, 8'($urandom), 5'($urandom)));
      end else if (pick < 91) begin
        send_item(make_item(OP_IGNORED, 8'($urandom), 5'($urandom)));
      end else begin
        send_item(make_item(2'($urandom), 8'($urandom), 5'($urandom)));
      end
    end
  endtask

  task automatic pick_idling();
    sender_idles   = $urandom_range(0, 3) != 0;
    receiver_idles = $urandom_range(0, 3) != 0;
  endtask

  initial begin
    int leftover;
    int failures;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed text at the reset bin setting.
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    read_bin(5'd0);
    send_char(CHAR_SPACE);
    send_char(8'h61);
    send_char(CHAR_SPACE);
    send_char(8'h62);
    send_char(8'h63);
    send_char(CHAR_TAB);
    send_char(8'h64);
    send_char(CHAR_NEWLINE);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CHAR_SPACE);
    read_bin(5'd31);
    read_bin(5'd1);
    send_item(make_item(OP_IGNORED, 8'hFF, 5'd31));
    open_word(3);
    send_item(make_item(OP_CLEAR, 8'hFF, 5'd31));
    send_char(CHAR_SPACE);
    read_bin(5'd2);

    // Leave a long word open, then shrink the bins under it.
    open_word(20);
    write_bins(6'd5);
    send_char(CHAR_TAB);
    run_text(100);

    // One bin: hammer bin 0, closing a word on every other item, at full rate.
    write_bins(6'd1);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    repeat (100) begin
      send_char(random_word_byte());
      send_char(CHAR_SPACE);
    end
    read_bin(5'd0);
    read_bin(5'd1);
    send_item(make_item(OP_CLEAR, 8'h00, 5'd0));
    read_bin(5'd0);
    pick_idling();
    run_text(60);

    open_word(10);
    write_bins(6'd0);
    send_char(CHAR_NEWLINE);
    run_text(80);

    write_bins(6'd63);
    pick_idling();
    run_text(100);

    write_bins(6'd33);
    run_text(80);

    write_bins(6'd32);
    pick_idling();
    run_text(120);

    // Long output hold-off while input keeps coming, so the block backs up.
    sender_idles = 1'b0;
    hold_request = 1'b1;
    run_text(60);

    repeat (3) begin
      open_word($urandom_range(0, 12));
      write_bins(6'($urandom_range(0, 63)));
      pick_idling();
      run_text(80);
    end

    // Final stretch with no idling on either side.
    write_bins(6'($urandom_range(0, 63)));
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_text(120);

    wait_until_drained();
    repeat (8) @(posedge clk);
    leftover = tracker.pending_reports.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    failures = tracker.mismatches + tracker.unexpected + leftover;
    $display("Run covered %0d input transfers: %0d words counted, %0d bin reads, %0d clears.",
             items_offered, tracker.words_closed, tracker.reads, tracker.clears);
    $display("%0d bin settings written, bin 0 hit back to back, one long output hold-off.",
             settings_written);
    if (failures == 0) begin
      $display("word_length_histogram verification clean");
    end else begin
      $display("word_length_histogram verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/wlh_pkg.sv
hdl/word_length_histogram.sv
hdl/wlh_checker.sv
dv/tb_word_length_histogram.sv
